[hw/rtl/lnps_pkg.sv]
// shared types and constants for the last-note priority stack
// no dependencies; imported by every module of the block

package lnps_pkg;

  // stack depth used when the top level is not overridden
  localparam int DEF_STACK_DEPTH = 16;

  // field widths fixed by the stream format
  localparam int NOTE_W      = 7;
  localparam int DEPTH_W     = 5;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  typedef logic [NOTE_W-1:0] note_t;

  // key event kind carried on in_tuser
  typedef enum logic {
    CMD_PRESS   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  // control broadcast from the top level to every cell
  typedef struct packed {
    logic upd;    // a word is accepted this cycle
    logic press;  // the event is a key press
    logic hold;   // press with no match on a full stack: stack stays as is
  } lnps_ctrl_t;

endpackage

[hw/rtl/lnps_cell.sv]
// one stack cell: holds one note, compares it with the key and shifts
// toward its neighbors; depends on lnps_pkg

module lnps_cell
  import lnps_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int IDX         = 0
) (
  input  logic                               clk,
  input  lnps_ctrl_t                         ctrl,
  input  note_t                              key_note,
  input  logic [$clog2(STACK_DEPTH+1)-1:0]   held_total,
  input  logic                               hit_in,    // match in a cell nearer the top
  input  note_t                              prev_note, // neighbor nearer the top (or key)
  input  note_t                              next_note, // neighbor farther from the top
  output logic                               hit_out,
  output note_t                              note_q,
  output note_t                              note_nxt
);

  localparam int CW = $clog2(STACK_DEPTH+1);

  note_t note_r;
  logic  occupied;
  logic  match;

  // a cell is part of the stack when its position is below the count
  assign occupied = (held_total > CW'(IDX));
  assign match    = occupied && (note_r == key_note);
  assign hit_out  = hit_in | match;

  // press: cells above the removed copy move one place down and the key
  // lands in cell 0; release: cells from the removed copy on move up
  always_comb begin
    note_nxt = note_r;
    if (ctrl.press) begin
      if (!ctrl.hold && !hit_in) begin
        note_nxt = prev_note;
      end
    end else begin
      if (hit_in || match) begin
        note_nxt = next_note;
      end
    end
  end

  // note storage, written only on an accepted word
  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      note_r <= note_nxt;
    end
  end

  assign note_q = note_r;

endmodule

[hw/rtl/last_note_priority_stack_unit.sv]
// Last-note priority note stack for a monophonic voice.
// Input stream: in_tuser is the event kind (0 press, 1 release) and in_tdata
// carries the note number. Every accepted word yields exactly one result word
// on the output stream: sound_on, the note to play, whether a press was
// stored, and the number of held notes after the event.
// The stack is a row of STACK_DEPTH cells with the most recent note in cell 0.
// On each accepted word every cell compares its note with the key, a match
// flag ripples along the row, and all cells shift and compact in the same
// cycle, so the stack never holds duplicates.
// The result is registered and appears in the cycle after the word is accepted.
// One word per cycle while the receiver takes each result; the row of cells
// finishes an event on accept, and the result register holds it until it is taken.
// When the receiver stalls, the result stays in the output register and
// in_tready drops until it is taken; a word is accepted in the same cycle the
// pending result leaves.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result; cell contents are left as they are and are never read until written.
// Depends on lnps_pkg and lnps_cell.

module last_note_priority_stack_unit
  import lnps_pkg::*;
#(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [6:0] key_note, [7] zero
  input  logic                   in_tuser,   // [0] cmd
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [0] sound_on, [7:1] play_note,
                                             // [8] was_stored, [13:9] depth_now,
                                             // [15:14] zero
);

  localparam int CW = $clog2(STACK_DEPTH+1);

  logic [CW-1:0]      held_total_r, held_total_nxt;
  logic [CW-1:0]      total_dropped;
  logic               out_valid_r, out_valid_nxt;
  logic               sound_on_r, sound_on_nxt;
  note_t              play_note_r, play_note_nxt;
  logic               was_stored_r, was_stored_nxt;
  logic [DEPTH_W-1:0] depth_now_r, depth_now_nxt;
  logic [CW+DEPTH_W-1:0] total_ext;

  logic       accept;
  cmd_t       cmd;
  note_t      key_note;
  logic       room;
  lnps_ctrl_t ctrl;

  logic [STACK_DEPTH:0] hit;
  note_t                note_q   [STACK_DEPTH];
  note_t                note_nxt [STACK_DEPTH];

  // input handshake and field unpacking
  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign key_note  = in_tdata[NOTE_W-1:0];

  // count after any copy is removed, and whether a push fits
  assign total_dropped = held_total_r - CW'(hit[STACK_DEPTH]);
  assign room          = (total_dropped < CW'(STACK_DEPTH));

  assign ctrl.upd   = accept;
  assign ctrl.press = (cmd == CMD_PRESS);
  assign ctrl.hold  = (cmd == CMD_PRESS) && !room;

  // row of cells, cell 0 holds the stack top
  assign hit[0] = 1'b0;
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    note_t prev_n;
    note_t next_n;
    if (i == 0) begin : g_first
      assign prev_n = key_note;
    end else begin : g_mid
      assign prev_n = note_q[i-1];
    end
    if (i == STACK_DEPTH-1) begin : g_last
      assign next_n = note_q[i];
    end else begin : g_inner
      assign next_n = note_q[i+1];
    end
    lnps_cell #(
      .STACK_DEPTH (STACK_DEPTH),
      .IDX         (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .key_note   (key_note),
      .held_total (held_total_r),
      .hit_in     (hit[i]),
      .prev_note  (prev_n),
      .next_note  (next_n),
      .hit_out    (hit[i+1]),
      .note_q     (note_q[i]),
      .note_nxt   (note_nxt[i])
    );
  end

  // new count and result fields
  always_comb begin
    held_total_nxt = total_dropped;
    was_stored_nxt = 1'b0;
    if (ctrl.press && room) begin
      held_total_nxt = total_dropped + CW'(1);
      was_stored_nxt = 1'b1;
    end
    if (ctrl.press) begin
      sound_on_nxt  = 1'b1;
      play_note_nxt = key_note;
    end else if (held_total_nxt != '0) begin
      sound_on_nxt  = 1'b1;
      play_note_nxt = note_nxt[0];
    end else begin
      sound_on_nxt  = 1'b0;
      play_note_nxt = '0;
    end
    total_ext     = {{DEPTH_W{1'b0}}, held_total_nxt};
    depth_now_nxt = total_ext[DEPTH_W-1:0];
  end

  // output word valid: set on accept, cleared when taken
  assign out_valid_nxt = accept || (out_valid_r && !out_tready);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        held_total_r <= held_total_nxt;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      sound_on_r   <= sound_on_nxt;
      play_note_r  <= play_note_nxt;
      was_stored_r <= was_stored_nxt;
      depth_now_r  <= depth_now_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, depth_now_r, was_stored_r, play_note_r, sound_on_r};

endmodule

[hw/rtl/lnps_chk.sv]
// port-level checker for the last-note priority stack, bound to the top level
// depends on lnps_pkg

module lnps_chk
  import lnps_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // reset leaves no pending result
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word pending after reset");

  // a press always sounds the pressed note in the next cycle
  a_press_sounds: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_PRESS)
      |=> out_tvalid && out_tdata[0] && (out_tdata[7:1] == $past(in_tdata[6:0])))
    else $error("pressed note not sounded");

  // a release never reports a stored note
  a_release_unstored: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == CMD_RELEASE) |=> out_tvalid && !out_tdata[8])
    else $error("release reported as stored");

  // silence means an empty stack and a zero note
  a_silence_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[13:1] == '0))
    else $error("silent result with held notes");

endmodule

bind last_note_priority_stack_unit lnps_chk u_lnps_chk (.*);
